### design/prime_weighted_word_hash_macros.svh
// Assertion macros for the prime weighted word hash.
// Each macro expects clk and arst_n in scope at the point of use.
`ifndef PRIME_WEIGHTED_WORD_HASH_MACROS_SVH
`define PRIME_WEIGHTED_WORD_HASH_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define PWWH_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pwwh assertion failed");
// Next-cycle implication.
`define PWWH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pwwh assertion failed");
`else
`define PWWH_ASSERT(lbl, ante, cons)
`define PWWH_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### design/pwwh_pkg.sv
`default_nettype none
package pwwh_pkg;

	localparam int DATA_W           = 64;
	localparam int CHAR_W           = 32;
	localparam int COUNT_WIDTH      = 32;
	localparam int PRIME_TABLE_SIZE = 16;
	localparam int PRIME_IDX_W      = 4;
	localparam int WEIGHT_W         = 6;
	localparam int CFG_IDX_W        = 2;
	localparam int OPQ_DEPTH        = 2;
	localparam int OPQ_PTR_W        = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
	localparam int OPQ_CNT_W        = $clog2(OPQ_DEPTH + 1);

	// Algorithm codes; the unused code behaves as the 64 bit checksum.
	localparam logic [1:0] ALG_HASH  = 2'd0;
	localparam logic [1:0] ALG_SUM32 = 2'd1;
	localparam logic [1:0] ALG_SUM64 = 2'd2;

	// Character width codes; the unused code behaves as four byte characters.
	localparam logic [1:0] WID_8  = 2'd0;
	localparam logic [1:0] WID_16 = 2'd1;
	localparam logic [1:0] WID_32 = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ALGORITHM  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHAR_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED       = 2'd2;

	typedef struct packed {
		logic [1:0]        algorithm;
		logic [1:0]        char_width_code;
		logic [DATA_W-1:0] seed;
	} cfg_t;

	// One accumulate operation: acc = base + value * weight + count.
	typedef struct packed {
		logic [DATA_W-1:0]      value;
		logic [WEIGHT_W-1:0]    weight;
		logic [COUNT_WIDTH-1:0] count;
		logic                   first;
		logic                   finish;
		logic                   sum32;
		logic [DATA_W-1:0]      seed;
	} op_t;

	function automatic logic [WEIGHT_W-1:0] prime_weight(input logic [PRIME_IDX_W-1:0] idx);
		logic [WEIGHT_W-1:0] w;
		case (idx)
			4'd0:    w = 6'd1;
			4'd1:    w = 6'd2;
			4'd2:    w = 6'd3;
			4'd3:    w = 6'd5;
			4'd4:    w = 6'd7;
			4'd5:    w = 6'd11;
			4'd6:    w = 6'd13;
			4'd7:    w = 6'd17;
			4'd8:    w = 6'd19;
			4'd9:    w = 6'd23;
			4'd10:   w = 6'd29;
			4'd11:   w = 6'd31;
			4'd12:   w = 6'd37;
			4'd13:   w = 6'd41;
			4'd14:   w = 6'd43;
			4'd15:   w = 6'd47;
			default: w = 6'd1;
		endcase
		return w;
	endfunction

	function automatic logic [1:0] norm_width(input logic [1:0] code);
		return (code == WID_8 || code == WID_16) ? code : WID_32;
	endfunction

endpackage
`default_nettype wire

### design/pwwh_front.sv
`default_nettype none
module pwwh_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_push,
	input  wire logic                             q_full,
	input  wire logic [pwwh_pkg::CHAR_W-1:0]      char_code,
	input  wire logic                             last_char,
	input  wire logic                             empty_message,
	input  wire pwwh_pkg::cfg_t                   cfg,
	output logic                                  op_push,
	output pwwh_pkg::op_t                         op
);
	import pwwh_pkg::*;

	logic                   open_q;
	logic                   hash_q;
	logic                   sum32_q;
	logic [1:0]             width_q;
	logic [DATA_W-1:0]      word_q;
	logic [2:0]             lane_q;
	logic [PRIME_IDX_W-1:0] prime_q;
	logic [COUNT_WIDTH-1:0] count_q;

	logic                   hash;
	logic                   sum32;
	logic [1:0]             width;
	logic [DATA_W-1:0]      ch;
	logic [5:0]             shamt;
	logic                   last_lane;
	logic                   finish;
	logic                   full_word;
	logic [DATA_W-1:0]      word_n;
	logic [COUNT_WIDTH-1:0] count_n;
	logic [PRIME_IDX_W-1:0] prime_n;
	logic                   accept;

	assign accept  = in_push && !q_full;
	assign op_push = accept;

	always_comb begin
		// Settings latched for an open message, fresh ones for its first item.
		hash  = open_q ? hash_q : (cfg.algorithm == ALG_HASH);
		sum32 = open_q ? sum32_q : (cfg.algorithm == ALG_SUM32);
		width = open_q ? width_q : norm_width(cfg.char_width_code);

		case (width)
			WID_8: begin
				ch        = {{(DATA_W-8){1'b0}}, char_code[7:0]};
				shamt     = {lane_q, 3'b000};
				last_lane = (lane_q == 3'd7);
			end
			WID_16: begin
				ch        = {{(DATA_W-16){1'b0}}, char_code[15:0]};
				shamt     = {lane_q[1:0], 4'b0000};
				last_lane = (lane_q == 3'd3);
			end
			default: begin
				ch        = {{(DATA_W-CHAR_W){1'b0}}, char_code};
				shamt     = {lane_q[0], 5'b00000};
				last_lane = (lane_q == 3'd1);
			end
		endcase

		finish    = empty_message || last_char;
		full_word = !empty_message && last_lane;
		word_n    = empty_message ? word_q : (word_q | (ch << shamt));
		count_n   = empty_message ? count_q : count_q + 1'b1;
		prime_n   = (prime_q == PRIME_IDX_W'(PRIME_TABLE_SIZE - 1)) ? '0 : prime_q + 1'b1;

		op.first  = !open_q;
		op.finish = finish;
		op.sum32  = sum32;
		op.seed   = hash ? cfg.seed : '0;
		if (hash) begin
			op.value  = (full_word || finish) ? word_n : '0;
			op.weight = prime_weight(prime_q);
			op.count  = finish ? count_n : '0;
		end else begin
			op.value  = empty_message ? '0 : ch;
			op.weight = WEIGHT_W'(1);
			op.count  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			hash_q  <= 1'b1;
			sum32_q <= 1'b0;
			width_q <= WID_8;
			word_q  <= '0;
			lane_q  <= '0;
			prime_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (finish) begin
				open_q  <= 1'b0;
				word_q  <= '0;
				lane_q  <= '0;
				prime_q <= '0;
				count_q <= '0;
			end else begin
				open_q  <= 1'b1;
				hash_q  <= hash;
				sum32_q <= sum32;
				width_q <= width;
				count_q <= count_n;
				if (hash && full_word) begin
					word_q  <= '0;
					lane_q  <= '0;
					prime_q <= prime_n;
				end else if (hash) begin
					word_q <= word_n;
					lane_q <= lane_q + 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

### design/pwwh_opq.sv
`default_nettype none
module pwwh_opq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire pwwh_pkg::op_t push_op,
	output logic               full,
	input  wire logic          pop,
	output pwwh_pkg::op_t      head,
	output logic               empty
);
	import pwwh_pkg::*;

	op_t                  mem [OPQ_DEPTH];
	logic [OPQ_PTR_W-1:0] wr_ptr_q;
	logic [OPQ_PTR_W-1:0] rd_ptr_q;
	logic [OPQ_CNT_W-1:0] cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = (cnt_q == OPQ_CNT_W'(OPQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### design/pwwh_back.sv
`default_nettype none
module pwwh_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pwwh_pkg::op_t                 head,
	input  wire logic                          q_empty,
	output logic                               q_pop,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [pwwh_pkg::DATA_W-1:0]        digest
);
	import pwwh_pkg::*;

	logic [DATA_W-1:0]          acc_q;
	logic [DATA_W-1:0]          digest_q;
	logic                       res_valid_q;
	logic [DATA_W-1:0]          base;
	logic [DATA_W+WEIGHT_W-1:0] prod;
	logic [DATA_W-1:0]          sum;

	// Take an op unless it ends a message and the result slot stays occupied.
	assign q_pop  = !q_empty && (!head.finish || !res_valid_q || pop);
	assign empty  = !res_valid_q;
	assign digest = digest_q;

	always_comb begin
		base = head.first ? head.seed : acc_q;
		prod = head.value * head.weight;
		sum  = base + prod[DATA_W-1:0] + DATA_W'(head.count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				acc_q <= sum;
			end
			if (q_pop && head.finish) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && head.finish) begin
			digest_q <= head.sum32 ? {{(DATA_W-32){1'b0}}, sum[31:0]} : sum;
		end
	end

endmodule
`default_nettype wire

### design/prime_weighted_word_hash.sv
`default_nettype none
// Prime weighted word hash and sum checksum over a character stream. Push one
// character per transfer; the transfer with last_char or empty_message high ends
// the message and produces exactly one digest, all other transfers produce none.
// The algorithm, character width and seed are sampled on the first character of
// each message, so writes made mid-message apply to the next one. In hash mode
// characters pack little-endian into 64-bit words (8, 4 or 2 characters), each
// word is weighted by the next of 16 small primes and added to an accumulator
// that starts at the seed, and the character count is added at the end; in
// checksum mode characters are summed from zero (32-bit mode masks the digest).
// Rate: one character per cycle while the reader keeps up. A digest reaches
// the result ports through the operation queue and the result register after
// the transfer that ends its message is accepted, and later while an earlier
// digest still waits for the reader. The front stage packs the words; the back
// stage does one multiply by a 6-bit prime and a 64-bit accumulate per cycle,
// which sets that rate. A two-entry operation queue between the stages and a
// one-entry result register let a stalled reader hold back the back stage
// while the front keeps taking characters until the queue fills.
module prime_weighted_word_hash (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [pwwh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pwwh_pkg::DATA_W-1:0]        cfg_data,
	input  wire logic                               push,
	output logic                                    full,
	input  wire logic [pwwh_pkg::CHAR_W-1:0]        char_code,
	input  wire logic                               last_char,
	input  wire logic                               empty_message,
	output logic                                    empty,
	input  wire logic                               pop,
	output logic [pwwh_pkg::DATA_W-1:0]             digest
);
	import pwwh_pkg::*;
`include "prime_weighted_word_hash_macros.svh"

	cfg_t cfg_q;
	op_t  op_front;
	op_t  op_head;
	logic op_push;
	logic q_full;
	logic q_empty;
	logic q_pop;

	// Configuration registers; writes to an index beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.algorithm       <= ALG_HASH;
			cfg_q.char_width_code <= WID_8;
			cfg_q.seed            <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ALGORITHM:  cfg_q.algorithm       <= cfg_data[1:0];
				CFG_CHAR_WIDTH: cfg_q.char_width_code <= cfg_data[1:0];
				CFG_SEED:       cfg_q.seed            <= cfg_data;
				default:        cfg_q                 <= cfg_q;
			endcase
		end
	end

	// Front stage: classify each character and pack words.
	pwwh_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_push       (push),
		.q_full        (q_full),
		.char_code     (char_code),
		.last_char     (last_char),
		.empty_message (empty_message),
		.cfg           (cfg_q),
		.op_push       (op_push),
		.op            (op_front)
	);

	// Hold pending accumulate operations between the stages.
	pwwh_opq u_opq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (op_push),
		.push_op (op_front),
		.full    (q_full),
		.pop     (q_pop),
		.head    (op_head),
		.empty   (q_empty)
	);

	// Back stage: multiply-accumulate and result register.
	pwwh_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (op_head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.digest  (digest)
	);

	assign full = q_full;

	// A finishing op taken by the back stage leaves a result waiting.
	`PWWH_ASSERT_NEXT(a_finish_gives_result, q_pop && op_head.finish, !empty)
	// A finishing op is taken only when the result slot is free or draining.
	`PWWH_ASSERT(a_no_result_overwrite, q_pop && op_head.finish, empty || pop)
	// A new result appears only after a finishing op was taken.
	`PWWH_ASSERT(a_result_has_source, $fell(empty), $past(q_pop && op_head.finish))

endmodule
`default_nettype wire

### bench/tb_prime_weighted_word_hash.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_prime_weighted_word_hash;
	import pwwh_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 4;   // idle margin after the block drains
	localparam int DRAIN_CYCLES  = 12;
	localparam int MAX_REPORTED  = 10;
	localparam int HOLD_CYCLES   = 300;

	// Codes the package leaves unnamed; both alias a named code.
	localparam logic [1:0] ALG_UNUSED = 2'd3;
	localparam logic [1:0] WID_UNUSED = 2'd3;

	localparam logic [WEIGHT_W-1:0] PRIMES [16] = '{
		6'd1, 6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17,
		6'd19, 6'd23, 6'd29, 6'd31, 6'd37, 6'd41, 6'd43, 6'd47
	};

	// DUT ports; the inputs are driven to known values from time zero.
	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [DATA_W-1:0]    cfg_data      = '0;
	logic                 push          = 1'b0;
	logic                 full;
	logic [CHAR_W-1:0]    char_code     = '0;
	logic                 last_char     = 1'b0;
	logic                 empty_message = 1'b0;
	logic                 empty;
	logic                 pop           = 1'b0;
	logic [DATA_W-1:0]    digest;

	prime_weighted_word_hash u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.push          (push),
		.full          (full),
		.char_code     (char_code),
		.last_char     (last_char),
		.empty_message (empty_message),
		.empty         (empty),
		.pop           (pop),
		.digest        (digest)
	);

	// 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shaping knobs, set by the test tasks.
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_left      = 0;   // receiver hold-off, counted down below

	int unsigned items_sent   = 0;
	int unsigned digest_errors = 0;
	int unsigned cycle_count  = 0;

	logic [DATA_W-1:0] pending_digests [$];

	// ------------------------------------------------------------------
	// Predictor: shadow registers plus the per-message hash state.
	// ------------------------------------------------------------------
	logic [1:0]             reg_alg   = ALG_HASH;
	logic [1:0]             reg_width = WID_8;
	logic [DATA_W-1:0]      reg_seed  = '0;

	logic [DATA_W-1:0]      acc;
	logic [DATA_W-1:0]      word_buf;
	int unsigned            lane;
	int unsigned            prime_idx;
	logic [COUNT_WIDTH-1:0] n_chars;
	bit                     msg_open  = 1'b0;
	logic [1:0]             msg_alg;
	logic [1:0]             msg_width;

	// Weight the packed word by the next prime and fold it into the sum.
	function automatic void flush_word();
		acc = acc + word_buf * DATA_W'(PRIMES[prime_idx]);
		prime_idx = (prime_idx + 1) % PRIME_TABLE_SIZE;
		word_buf = '0;
		lane = 0;
	endfunction

	// Advance the hash by one transfer; return 1 with the digest when the
	// transfer closes the message.
	function automatic bit advance_hash(input logic [CHAR_W-1:0] code, input bit is_last,
			input bit is_empty, output logic [DATA_W-1:0] dig);
		int unsigned bits;
		int unsigned per_word;
		logic [DATA_W-1:0] ch;
		dig = '0;
		// Latch the configuration on the first transfer of a message.
		if (!msg_open) begin
			msg_alg   = (reg_alg == ALG_UNUSED) ? ALG_SUM64 : reg_alg;
			msg_width = (reg_width == WID_UNUSED) ? WID_32 : reg_width;
			acc       = (msg_alg == ALG_HASH) ? reg_seed : '0;
			word_buf  = '0;
			lane      = 0;
			prime_idx = 0;
			n_chars   = '0;
			msg_open  = 1'b1;
		end
		bits = (msg_width == WID_8) ? 8 : (msg_width == WID_16) ? 16 : 32;
		per_word = DATA_W / bits;
		if (!is_empty) begin
			ch = DATA_W'(code) & ((64'd1 << bits) - 64'd1);
			n_chars = n_chars + 1'b1;
			if (msg_alg == ALG_HASH) begin
				word_buf = word_buf | (ch << (lane * bits));
				lane++;
				if (lane >= per_word)
					flush_word();
			end else begin
				acc = acc + ch;
			end
			if (!is_last)
				return 1'b0;
		end
		// Close the message: in hash mode flush any partial word, then add the count.
		if (msg_alg == ALG_HASH) begin
			if (lane != 0)
				flush_word();
			acc = acc + DATA_W'(n_chars);
			dig = acc;
		end else if (msg_alg == ALG_SUM32) begin
			dig = acc & 64'h0000_0000_FFFF_FFFF;
		end else begin
			dig = acc;
		end
		msg_open  = 1'b0;
		word_buf  = '0;
		lane      = 0;
		prime_idx = 0;
		n_chars   = '0;
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Receiver: drive pop at the falling edge, check at the rising edge.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			// Hold off so the block backs up into its input.
			hold_left = hold_left - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_digests.size() == 0) begin
				digest_errors++;
				if (digest_errors <= MAX_REPORTED)
					$display("unexpected digest %h at cycle %0d", digest, cycle_count);
			end else begin
				if (digest !== pending_digests[0]) begin
					digest_errors++;
					if (digest_errors <= MAX_REPORTED)
						$display("digest mismatch at cycle %0d: expected %h, got %h",
							cycle_count, pending_digests[0], digest);
				end
				void'(pending_digests.pop_front());
			end
		end
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sender side.
	// ------------------------------------------------------------------
	// Offer one character; idle at random first, then hold until the transfer.
	task automatic send_char(input logic [CHAR_W-1:0] code, input bit is_last,
			input bit is_empty);
		logic [DATA_W-1:0] dig;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 99) < send_idle_pct)
				push <= 1'b0;
			else
				break;
		end
		push          <= 1'b1;
		char_code     <= code;
		last_char     <= is_last;
		empty_message <= is_empty;
		do
			@(posedge clk);
		while (full);
		if (advance_hash(code, is_last, is_empty, dig))
			pending_digests.push_back(dig);
		items_sent++;
	endtask

	// Drop push; call only right after a transfer or another rising edge.
	task automatic stop_push();
		@(negedge clk);
		push <= 1'b0;
	endtask

	// Wait until the block has drained before touching the registers.
	task automatic settle();
		stop_push();
		wait (pending_digests.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			CFG_ALGORITHM:  reg_alg   = value[1:0];
			CFG_CHAR_WIDTH: reg_width = value[1:0];
			CFG_SEED:       reg_seed  = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Favor the corners: zero, all ones, the per-width maxima.
	function automatic logic [CHAR_W-1:0] rand_char();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return 32'h0000_00FF;
			3:       return 32'h0000_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Random registers, with noise above the code bits.
	task automatic configure_random();
		logic [DATA_W-1:0] noise;
		logic [DATA_W-1:0] seed_val;
		settle();
		noise = {$urandom, $urandom} & ~64'h3;
		write_reg(CFG_ALGORITHM, noise | DATA_W'($urandom_range(0, 3)));
		noise = {$urandom, $urandom} & ~64'h3;
		write_reg(CFG_CHAR_WIDTH, noise | DATA_W'($urandom_range(0, 3)));
		case ($urandom_range(0, 5))
			0:       seed_val = '0;
			1:       seed_val = '1;
			default: seed_val = {$urandom, $urandom};
		endcase
		write_reg(CFG_SEED, seed_val);
	endtask

	// One message of n characters, closed by last_char or by an empty item.
	task automatic send_message(input int unsigned n, input bit close_empty);
		if (n == 0) begin
			send_char($urandom, $urandom_range(0, 1), 1'b1);
			return;
		end
		for (int unsigned i = 0; i < n; i++)
			send_char(rand_char(), !close_empty && (i == n - 1), 1'b0);
		if (close_empty)
			send_char($urandom, $urandom_range(0, 1), 1'b1);
	endtask

	// Mostly short messages, some long enough to wrap the prime table.
	function automatic int unsigned rand_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 0;
		else if (r < 70)
			return $urandom_range(1, 10);
		else if (r < 92)
			return $urandom_range(11, 24);
		else
			return $urandom_range(25, 40);
	endfunction

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------
	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		// Reset configuration: an empty message digests to the zero seed.
		send_char('0, 1'b0, 1'b1);

		settle();
		write_reg(CFG_SEED, '1);
		write_reg(CFG_ALGORITHM, DATA_W'(ALG_HASH));
		write_reg(CFG_CHAR_WIDTH, DATA_W'(WID_8));
		// Upper bits of each character must be masked off.
		send_char('1, 1'b0, 1'b0);
		send_char('0, 1'b0, 1'b0);
		send_char('1, 1'b1, 1'b0);
		// Empty message: digest is the seed, last_char ignored.
		send_char(32'h1234_5678, 1'b1, 1'b1);
		// Empty item closes a message that already holds characters.
		send_char(32'h0000_00A5, 1'b0, 1'b0);
		send_char(32'h0000_005A, 1'b0, 1'b0);
		send_char('0, 1'b0, 1'b1);

		// Unused width code behaves as four byte characters.
		settle();
		write_reg(CFG_CHAR_WIDTH, DATA_W'(WID_UNUSED));
		send_char('1, 1'b0, 1'b0);
		send_char('1, 1'b0, 1'b0);
		send_char('1, 1'b1, 1'b0);

		settle();
		write_reg(CFG_CHAR_WIDTH, DATA_W'(WID_16));
		send_char(32'h8000_FFFF, 1'b0, 1'b0);
		send_char(32'h0001_0000, 1'b1, 1'b0);

		// 32 bit checksum wraps and is masked.
		settle();
		write_reg(CFG_CHAR_WIDTH, DATA_W'(WID_32));
		write_reg(CFG_ALGORITHM, DATA_W'(ALG_SUM32));
		send_char('1, 1'b0, 1'b0);
		send_char('1, 1'b1, 1'b0);

		// Unused algorithm code behaves as the 64 bit checksum.
		settle();
		write_reg(CFG_ALGORITHM, DATA_W'(ALG_UNUSED));
		send_char('1, 1'b0, 1'b0);
		send_char('1, 1'b1, 1'b0);
		// Empty checksum message digests to zero.
		send_char('0, 1'b1, 1'b1);
	endtask

	task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned n_items);
		int unsigned start;
		start = items_sent;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		while (items_sent - start < n_items) begin
			configure_random();
			repeat ($urandom_range(2, 6))
				send_message(rand_length(), $urandom_range(0, 4) == 0);
		end
	endtask

	// Stall the reader long enough that full rises while items keep coming.
	task automatic test_backpressure();
		configure_random();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left = HOLD_CYCLES;
		repeat (40)
			send_message($urandom_range(1, 3), 1'b0);
	endtask

	// Pause mid-message until every digest is out, then finish the message.
	task automatic test_sender_pause();
		send_idle_pct  = 22;
		recv_stall_pct = 22;
		repeat (6) begin
			configure_random();
			send_message($urandom_range(1, 5), 1'b0);
			repeat ($urandom_range(1, 6))
				send_char(rand_char(), 1'b0, 1'b0);
			stop_push();
			wait (pending_digests.size() == 0);
			repeat ($urandom_range(1, 20)) @(posedge clk);
			send_message($urandom_range(0, 6), $urandom_range(0, 1));
		end
	endtask

	initial begin
		// Hold reset from time zero, release it on a falling edge.
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_phase(0, 0, 300);
		test_random_phase(52, 0, 300);
		test_random_phase(0, 52, 300);
		test_random_phase(22, 22, 300);
		test_backpressure();
		test_sender_pause();

		// Drain, then idle for DRAIN_CYCLES so that stray digests show.
		stop_push();
		wait (pending_digests.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (digest_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
